// File: hw/rtl/ogmm_pkg.sv
// Shared types and constants for the occupancy grid max-merge block.
package ogmm_pkg;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;
	localparam int S_DW   = 40;
	localparam int M_DW   = 24;
	localparam int COST_W = 7;
	localparam int LOC_W  = 35;
	localparam int PROD_W = 51;
	localparam int ACC_W  = 53;
	localparam int FRAC_W = 31;
	localparam int IDX_W  = ACC_W - FRAC_W;

	localparam logic [23:0] RST_STEP = 24'd65536;
	localparam logic [15:0] RST_COS  = 16'd16384;

	typedef enum logic [2:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_STEP        = 3'd2,
		REG_POSE_X      = 3'd3,
		REG_POSE_Y      = 3'd4,
		REG_HEADING_COS = 3'd5,
		REG_HEADING_SIN = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_MERGED  = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_OUTSIDE = 2'd2,
		ST_READ    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MUL_LX_C = 2'd0,
		MUL_LY_S = 2'd1,
		MUL_LX_S = 2'd2,
		MUL_LY_C = 2'd3
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE   = 3'd0,
		ACC_X_INIT = 3'd1,
		ACC_X_SUB  = 3'd2,
		ACC_Y_INIT = 3'd3,
		ACC_Y_ADD  = 3'd4
	} acc_op_t;

	typedef struct packed {
		logic     clr;
		logic     load;
		logic     loc;
		logic     mul;
		mul_sel_t msel;
		acc_op_t  acc;
		logic     rd;
		logic     wr;
		logic     push;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_read;
		logic in_unknown;
		logic in_map;
	} sts_t;

endpackage

// File: hw/rtl/ogmm_dp.sv
// Datapath: configuration registers, coordinate transform, cost grid memory and result registers.
module ogmm_dp #(
	parameter int MAP_WIDTH  = 256,
	parameter int MAP_HEIGHT = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ogmm_pkg::cmd_t               cmd,
	output ogmm_pkg::sts_t               sts,
	input  logic                         cfg_valid,
	input  logic [ogmm_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [ogmm_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                         s_tuser,
	input  logic [ogmm_pkg::S_DW-1:0]    s_tdata,
	output logic [1:0]                   m_tuser,
	output logic [ogmm_pkg::M_DW-1:0]    m_tdata
);

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [31:0] origin_x_q, origin_y_q, pose_x_q, pose_y_q;
	logic [23:0] step_q;
	logic signed [15:0] cos_q, sin_q;

	logic       op_q;
	logic [7:0] col_q, row_q, mx_q, my_q;
	logic [ogmm_pkg::COST_W-1:0] cost_q;

	logic signed [ogmm_pkg::LOC_W-1:0]  lx_q, ly_q;
	logic signed [ogmm_pkg::LOC_W-1:0]  mul_a;
	logic signed [15:0]                 mul_b;
	logic signed [ogmm_pkg::PROD_W-1:0] prod_q;
	logic [ogmm_pkg::ACC_W-1:0]         acc_x_q, acc_y_q;
	logic [ogmm_pkg::ACC_W-1:0]         pose_x_ext, pose_y_ext, prod_ext;
	logic [32:0]                        colp, rowp;

	logic [ogmm_pkg::IDX_W-1:0] sel_x, sel_y;
	logic                       in_map;
	logic [AW-1:0]              addr, addr_q, clr_cnt_q;

	logic [ogmm_pkg::COST_W-1:0] grid_q [DEPTH];
	logic [ogmm_pkg::COST_W-1:0] rdata_q, merged;
	logic                        bigger;

	logic [1:0]                  res_status_q;
	logic [ogmm_pkg::COST_W-1:0] res_cost_q;
	logic [7:0]                  res_x_q, res_y_q;
	logic [1:0]                  m_tuser_q;
	logic [ogmm_pkg::M_DW-1:0]   m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			step_q     <= ogmm_pkg::RST_STEP;
			pose_x_q   <= '0;
			pose_y_q   <= '0;
			cos_q      <= ogmm_pkg::RST_COS;
			sin_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ogmm_pkg::REG_ORIGIN_X:    origin_x_q <= cfg_data;
				ogmm_pkg::REG_ORIGIN_Y:    origin_y_q <= cfg_data;
				ogmm_pkg::REG_STEP:        step_q     <= cfg_data[23:0];
				ogmm_pkg::REG_POSE_X:      pose_x_q   <= cfg_data;
				ogmm_pkg::REG_POSE_Y:      pose_y_q   <= cfg_data;
				ogmm_pkg::REG_HEADING_COS: cos_q      <= cfg_data[15:0];
				ogmm_pkg::REG_HEADING_SIN: sin_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign sts.in_read    = s_tuser;
	assign sts.in_unknown = s_tdata[23];
	assign sts.clr_last   = (clr_cnt_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign colp = 33'({col_q, 1'b1}) * 33'(step_q);
	assign rowp = 33'({row_q, 1'b1}) * 33'(step_q);

	always_comb begin
		case (cmd.msel)
			ogmm_pkg::MUL_LX_C: begin
				mul_a = lx_q;
				mul_b = cos_q;
			end
			ogmm_pkg::MUL_LY_S: begin
				mul_a = ly_q;
				mul_b = sin_q;
			end
			ogmm_pkg::MUL_LX_S: begin
				mul_a = lx_q;
				mul_b = sin_q;
			end
			default: begin
				mul_a = ly_q;
				mul_b = cos_q;
			end
		endcase
	end

	assign pose_x_ext = {{6{pose_x_q[31]}}, pose_x_q, 15'b0};
	assign pose_y_ext = {{6{pose_y_q[31]}}, pose_y_q, 15'b0};
	assign prod_ext   = {{2{prod_q[ogmm_pkg::PROD_W-1]}}, prod_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tuser;
			col_q  <= s_tdata[7:0];
			row_q  <= s_tdata[15:8];
			cost_q <= s_tdata[22:16];
			mx_q   <= s_tdata[31:24];
			my_q   <= s_tdata[39:32];
		end
		if (cmd.loc) begin
			lx_q <= $signed({{2{origin_x_q[31]}}, origin_x_q, 1'b0}) + $signed({2'b00, colp});
			ly_q <= $signed({{2{origin_y_q[31]}}, origin_y_q, 1'b0}) + $signed({2'b00, rowp});
		end
		if (cmd.mul) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.acc)
			ogmm_pkg::ACC_X_INIT: acc_x_q <= pose_x_ext + prod_ext;
			ogmm_pkg::ACC_X_SUB:  acc_x_q <= acc_x_q - prod_ext;
			ogmm_pkg::ACC_Y_INIT: acc_y_q <= pose_y_ext + prod_ext;
			ogmm_pkg::ACC_Y_ADD:  acc_y_q <= acc_y_q + prod_ext;
			default: ;
		endcase
	end

	assign sel_x = op_q ? ogmm_pkg::IDX_W'(mx_q) : acc_x_q[ogmm_pkg::ACC_W-1:ogmm_pkg::FRAC_W];
	assign sel_y = op_q ? ogmm_pkg::IDX_W'(my_q) : acc_y_q[ogmm_pkg::ACC_W-1:ogmm_pkg::FRAC_W];
	assign in_map = (op_q || (!acc_x_q[ogmm_pkg::ACC_W-1] && !acc_y_q[ogmm_pkg::ACC_W-1]))
		&& (32'(sel_x) < 32'(MAP_WIDTH)) && (32'(sel_y) < 32'(MAP_HEIGHT));
	assign sts.in_map = in_map;
	assign addr = AW'(32'(sel_y) * 32'(MAP_WIDTH) + 32'(sel_x));

	assign bigger = (cost_q > rdata_q);
	assign merged = bigger ? cost_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			grid_q[clr_cnt_q] <= '0;
		end else if (cmd.wr && !op_q && bigger) begin
			grid_q[addr_q] <= cost_q;
		end
		if (cmd.rd && in_map) begin
			rdata_q <= grid_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !s_tuser && s_tdata[23]) begin
			res_status_q <= ogmm_pkg::ST_UNKNOWN;
			res_cost_q   <= '0;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end
		if (cmd.rd) begin
			addr_q <= addr;
			if (!in_map) begin
				res_status_q <= ogmm_pkg::ST_OUTSIDE;
				res_cost_q   <= '0;
			end
			if (in_map || op_q) begin
				res_x_q <= sel_x[7:0];
				res_y_q <= sel_y[7:0];
			end else begin
				res_x_q <= '0;
				res_y_q <= '0;
			end
		end
		if (cmd.wr) begin
			res_status_q <= op_q ? ogmm_pkg::ST_READ : ogmm_pkg::ST_MERGED;
			res_cost_q   <= op_q ? rdata_q : merged;
		end
		if (cmd.push) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {1'b0, res_y_q, res_x_q, res_cost_q};
		end
	end

	assign m_tuser = m_tuser_q;
	assign m_tdata = m_tdata_q;

endmodule

// File: hw/rtl/ogmm_ctrl.sv
// Controller: sequences the clearing pass, the transform steps, the grid access and the result transfer.
module ogmm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  ogmm_pkg::sts_t sts,
	output ogmm_pkg::cmd_t cmd,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready
);

	typedef enum logic [10:0] {
		S_CLR  = 11'b000_0000_0001,
		S_IDLE = 11'b000_0000_0010,
		S_LOC  = 11'b000_0000_0100,
		S_M0   = 11'b000_0000_1000,
		S_M1   = 11'b000_0001_0000,
		S_M2   = 11'b000_0010_0000,
		S_M3   = 11'b000_0100_0000,
		S_M4   = 11'b000_1000_0000,
		S_RD   = 11'b001_0000_0000,
		S_WR   = 11'b010_0000_0000,
		S_PUSH = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.in_read) state_d = S_RD;
					else if (sts.in_unknown) state_d = S_PUSH;
					else state_d = S_LOC;
				end
			end
			S_LOC: begin
				cmd.loc = 1'b1;
				state_d = S_M0;
			end
			S_M0: begin
				cmd.mul  = 1'b1;
				cmd.msel = ogmm_pkg::MUL_LX_C;
				state_d  = S_M1;
			end
			S_M1: begin
				cmd.mul  = 1'b1;
				cmd.msel = ogmm_pkg::MUL_LY_S;
				cmd.acc  = ogmm_pkg::ACC_X_INIT;
				state_d  = S_M2;
			end
			S_M2: begin
				cmd.mul  = 1'b1;
				cmd.msel = ogmm_pkg::MUL_LX_S;
				cmd.acc  = ogmm_pkg::ACC_X_SUB;
				state_d  = S_M3;
			end
			S_M3: begin
				cmd.mul  = 1'b1;
				cmd.msel = ogmm_pkg::MUL_LY_C;
				cmd.acc  = ogmm_pkg::ACC_Y_INIT;
				state_d  = S_M4;
			end
			S_M4: begin
				cmd.acc = ogmm_pkg::ACC_Y_ADD;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = sts.in_map ? S_WR : S_PUSH;
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hw/rtl/occupancy_grid_max_merge.sv
// Top level of the occupancy grid max-merge block.
// The block holds a MAP_WIDTH x MAP_HEIGHT grid of 7-bit costs. After reset it runs a
// clearing pass over all MAP_WIDTH*MAP_HEIGHT entries (65536 at the defaults), one entry
// per cycle, with s_tready low; configuration writes are taken throughout. Items are
// handled one at a time: a merge with a known cost forms the local coordinates, makes
// four passes through the single shared 35x16 multiplier plus a final accumulate, then
// does a grid read and, when the cell lies on the grid, a read-modify-write before the
// result is pushed; a read does the grid read and, on the grid, a result update, and an
// unknown cost goes straight to the push. s_tready rises again in the same cycle as
// m_tvalid, once the result is loaded, so no new item is taken before then. The result sits
// in an output register, so the next item is taken while it waits for m_tready.
module occupancy_grid_max_merge #(
	parameter int MAP_WIDTH  = 256,
	parameter int MAP_HEIGHT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ogmm_pkg::CFG_IW-1:0] cfg_index,
	input  logic [ogmm_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic                        s_tuser,  // opcode
	input  logic [ogmm_pkg::S_DW-1:0]   s_tdata,  // local_col, local_row, cost_value, map_x, map_y
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [1:0]                  m_tuser,  // status
	output logic [ogmm_pkg::M_DW-1:0]   m_tdata   // cell_cost, cell_x, cell_y, zero pad
);

	ogmm_pkg::cmd_t cmd;
	ogmm_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ogmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	ogmm_dp #(
		.MAP_WIDTH  (MAP_WIDTH),
		.MAP_HEIGHT (MAP_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

endmodule

// File: hw/rtl/ogmm_checker.sv
// Port-level checker for the occupancy grid max-merge block, bound to the top level.
module ogmm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [1:0]                  m_tuser,
	input logic [ogmm_pkg::M_DW-1:0]   m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ogmm_pkg::ST_UNKNOWN |-> m_tdata == '0)
		else $error("skipped cell carries nonzero payload");

	a_outside_cost: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ogmm_pkg::ST_OUTSIDE |-> m_tdata[6:0] == '0)
		else $error("rejected cell carries a cost");

endmodule

bind occupancy_grid_max_merge ogmm_checker u_ogmm_checker (.*);
